FILE: rtl/cdq_pkg.sv
// Package: widths, command codes and ring index helpers for the circular deque.
`default_nettype none
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_NONE       = 3'd4
  } cmd_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [DATA_W-1:0] word_t;

  // Advance one slot, wrapping at the configured capacity.
  function automatic idx_t step_up(input idx_t idx, input cnt_t cap);
    cnt_t nx;
    nx = CNT_W'(idx) + CNT_W'(1);
    return (nx == cap) ? '0 : nx[IDX_W-1:0];
  endfunction

  // Retreat one slot, wrapping to capacity - 1.
  function automatic idx_t step_down(input idx_t idx, input cnt_t cap);
    cnt_t lst;
    lst = cap - CNT_W'(1);
    return (idx == '0) ? lst[IDX_W-1:0] : idx - IDX_W'(1);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cdq_if.sv
// Interfaces: request and response channels of the circular deque.
`default_nettype none
interface cdq_in_if;
  import cdq_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface cdq_out_if;
  import cdq_pkg::*;
  logic                valid;
  logic                ready;
  logic                ok;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;
  logic                is_empty;
  logic                is_full;
  logic [CNT_W-1:0]    count;

  modport source (output valid, ok, front_value, rear_value, is_empty, is_full, count,
                  input ready);
  modport sink   (input valid, ok, front_value, rear_value, is_empty, is_full, count,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/circular_deque_unit.sv
// Top level: double-ended queue kept in a ring memory with configurable capacity.
//
// Use:
//   in_req  : request channel (valid/ready) carrying cmd and value. cmd is
//             push front, push back, pop front, pop back or none; unused
//             codes act as none. A push into a full deque or a pop from an
//             empty one is refused with ok = 0 and changes nothing.
//   out_rsp : one response per request with ok, front and rear entries
//             (-1 when empty), empty and full flags and the entry count.
//   cfg_wr_en / cfg_wr_data : capacity register (1..16, 0 taken as 1,
//             larger values as 16). A write empties the deque. Write only
//             while no request is in flight.
// Timing: the accepting edge writes the ring memory, state ST_READ reads
//   front and rear from its two read ports, and state ST_RESP loads the
//   output register, from which the response is taken. One request is in
//   flight at a time: a new request is taken only after the response to
//   the last one has been loaded into the output register.
// Reset empties the deque and sets capacity to 16. When the receiver stalls
//   the response holds in the output register; one more request is taken
//   and waits for the register to free before the input stalls.
`default_nettype none
module circular_deque_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cdq_in_if.sink                     in_req,
  cdq_out_if.source                  out_rsp,
  input  wire logic                  cfg_wr_en,
  input  wire logic [cdq_pkg::CNT_W-1:0] cfg_wr_data
);
  import cdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_t;

  state_t state_r;
  idx_t   head_r, head_nxt;
  idx_t   tail_r, tail_nxt;
  cnt_t   count_r, count_nxt;
  cnt_t   cap_r, cap_nxt;
  logic   ok_r, ok_nxt;

  word_t  mem [DEPTH];
  word_t  front_rd_r, rear_rd_r;
  logic   wr_en;
  idx_t   wr_addr;

  logic   out_valid_r;
  logic   out_ok_r;
  word_t  out_front_r, out_rear_r;
  logic   out_empty_r, out_full_r;
  cnt_t   out_count_r;

  logic   accept;
  logic   rsp_load;
  logic   full, empty;
  cmd_t   cmd;

  assign accept   = in_req.valid && in_req.ready;
  assign rsp_load = (state_r == ST_RESP) && (!out_valid_r || out_rsp.ready);
  assign full     = (count_r >= cap_r);
  assign empty    = (count_r == '0);
  assign cmd      = cmd_t'(in_req.cmd);

  // Decode the request into new indexes and the memory write.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ok_nxt    = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          ok_nxt = 1'b0;
        end else begin
          head_nxt  = step_down(head_r, cap_r);
          wr_en     = accept;
          wr_addr   = head_nxt;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          ok_nxt = 1'b0;
        end else begin
          wr_en     = accept;
          wr_addr   = tail_r;
          tail_nxt  = step_up(tail_r, cap_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          ok_nxt = 1'b0;
        end else begin
          head_nxt  = step_up(head_r, cap_r);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          ok_nxt = 1'b0;
        end else begin
          tail_nxt  = step_down(tail_r, cap_r);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Clamp the written capacity to 1..DEPTH.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_nxt = CNT_W'(1);
    end else if (cfg_wr_data > CNT_W'(DEPTH)) begin
      cap_nxt = CNT_W'(DEPTH);
    end else begin
      cap_nxt = cfg_wr_data;
    end
  end

  // Ring memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_req.value;
    end
    if (state_r == ST_READ) begin
      front_rd_r <= mem[head_r];
      rear_rd_r  <= mem[step_down(tail_r, cap_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cap_r       <= CNT_W'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      if (rsp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cfg_wr_en) begin
            cap_r   <= cap_nxt;
            head_r  <= '0;
            tail_r  <= '0;
            count_r <= '0;
          end else if (accept) begin
            head_r  <= head_nxt;
            tail_r  <= tail_nxt;
            count_r <= count_nxt;
            ok_r    <= ok_nxt;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          // Hold until the output register is free.
          if (rsp_load) begin
            out_ok_r    <= ok_r;
            out_front_r <= empty ? '1 : front_rd_r;
            out_rear_r  <= empty ? '1 : rear_rd_r;
            out_empty_r <= empty;
            out_full_r  <= (count_r == cap_r);
            out_count_r <= count_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_req.ready        = (state_r == ST_IDLE) && !cfg_wr_en;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.ok          = out_ok_r;
  assign out_rsp.front_value = out_front_r;
  assign out_rsp.rear_value  = out_rear_r;
  assign out_rsp.is_empty    = out_empty_r;
  assign out_rsp.is_full     = out_full_r;
  assign out_rsp.count       = out_count_r;

endmodule
`default_nettype wire
